// File: hdl/edf_pkg.sv
package edf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_TASKS_DEF = 4;
  localparam int TIME_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int ACT_W     = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK0  = 3'd1;

  // Field positions inside a task setup word
  localparam int PER_LSB = 32;
  localparam int CMP_LSB = 16;
  localparam int DL_LSB  = 0;

  // Result field widths
  localparam int RUN_W  = 2;
  localparam int MASK_W = 4;

  localparam logic [ACT_W-1:0] ACTIVE_RST = 3'd4;

endpackage

// File: hdl/edf_tick_scheduler.sv
// Earliest-deadline-first tick scheduler.
// Input channel (in_valid/in_ready/in_restart): one request per scheduler tick.
// in_restart = 1 clears every counter so each enabled task is released on that
// tick. Result channel (out_valid/out_ready/out_*): one result per tick giving
// the task that ran (out_run_task, 0 when idle), out_idle, and the mask of tasks
// released on that tick.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 = active task count, index
// 1..4 = task setup (period 47:32, computation 31:16, relative deadline 15:0).
// Write only while no tick is in flight. Out-of-range indexes are dropped.
// Operation: a tick scans one task slot per cycle through a single update/compare
// unit, then charges the winner's budget in a final step and loads the result
// register. A new request is taken only once the block is back in idle, so it
// cannot accept the next tick before the current one has finished.
// The output register holds a finished result while the next tick is scanned;
// if the receiver still stalls when that tick finishes, the block waits in its
// final step until the result register frees up.
// Reset (synchronous, active low): all counters zero, setups zero, active count
// four, no result pending. Every enabled task is released on the first tick.
module edf_tick_scheduler #(
  parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = edf_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // tick requests
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_restart,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [edf_pkg::RUN_W-1:0]    out_run_task,
  output logic                         out_idle,
  output logic [edf_pkg::MASK_W-1:0]   out_released_mask,
  // configuration
  input  logic                         cfg_we,
  input  logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [edf_pkg::CFG_W-1:0]    cfg_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [edf_pkg::ACT_W-1:0] MAX_ACT = edf_pkg::ACT_W'(MAX_TASKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef logic [TIME_BITS-1:0] time_t;

  function automatic time_t count_down(input time_t v);
    count_down = (v == '0) ? '0 : (v - 1'b1);
  endfunction

  state_t state_r;

  // configuration
  logic [edf_pkg::ACT_W-1:0] active_r;
  time_t per_r [MAX_TASKS];
  time_t cmp_r [MAX_TASKS];
  time_t dln_r [MAX_TASKS];

  // per-task counters
  time_t rc_r  [MAX_TASKS];
  time_t bud_r [MAX_TASKS];
  time_t dc_r  [MAX_TASKS];

  // scan state
  logic [IDX_W-1:0]          k_r;
  logic                      restart_r;
  logic                      found_r;
  time_t                     best_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic [edf_pkg::MASK_W-1:0] mask_r;

  // result register
  logic                       out_valid_r;
  logic [edf_pkg::RUN_W-1:0]  out_run_r;
  logic                       out_idle_r;
  logic [edf_pkg::MASK_W-1:0] out_mask_r;

  // shared slot unit
  logic [edf_pkg::ACT_W-1:0]  used;
  logic                       enable;
  logic                       rel;
  time_t                      rc_e, bud_e, dc_e;
  time_t                      rc_new, bud_new, dc_new;
  logic                       take;
  logic                       last;
  logic [edf_pkg::MASK_W-1:0] mask_nxt;
  logic [edf_pkg::CFG_IDX_W-1:0] cfg_slot;
  logic                       cfg_task_hit;
  logic                       fin_go;

  always_comb begin
    used    = (active_r > MAX_ACT) ? MAX_ACT : active_r;
    rc_e    = restart_r ? '0 : rc_r[k_r];
    bud_e   = restart_r ? '0 : bud_r[k_r];
    dc_e    = restart_r ? '0 : dc_r[k_r];
    enable  = (edf_pkg::ACT_W'(k_r) < used) && (per_r[k_r] != '0);
    rel     = enable && (rc_e == '0);
    rc_new  = rel ? per_r[k_r] : rc_e;
    bud_new = rel ? cmp_r[k_r] : bud_e;
    dc_new  = rel ? dln_r[k_r] : dc_e;
    // strict less-than keeps ties on the lower slot
    take    = enable && (bud_new != '0) && (!found_r || (dc_new < best_r));
    last    = (k_r == LAST_IDX);
    mask_nxt = mask_r | (edf_pkg::MASK_W'(rel) << k_r);
    cfg_slot = cfg_index - edf_pkg::REG_TASK0;
    cfg_task_hit = (cfg_index >= edf_pkg::REG_TASK0) &&
                   (int'(cfg_slot) < MAX_TASKS);
    // final step may load the result register
    fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= edf_pkg::ACTIVE_RST;
      k_r         <= '0;
      restart_r   <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= '0;
      best_idx_r  <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      out_run_r   <= '0;
      out_idle_r  <= 1'b0;
      out_mask_r  <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        per_r[i] <= '0;
        cmp_r[i] <= '0;
        dln_r[i] <= '0;
        rc_r[i]  <= '0;
        bud_r[i] <= '0;
        dc_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == edf_pkg::REG_ACTIVE) begin
          active_r <= cfg_data[edf_pkg::ACT_W-1:0];
        end else if (cfg_task_hit) begin
          per_r[cfg_slot[IDX_W-1:0]] <= cfg_data[edf_pkg::PER_LSB +: TIME_BITS];
          cmp_r[cfg_slot[IDX_W-1:0]] <= cfg_data[edf_pkg::CMP_LSB +: TIME_BITS];
          dln_r[cfg_slot[IDX_W-1:0]] <= cfg_data[edf_pkg::DL_LSB +: TIME_BITS];
        end
      end

      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            restart_r <= in_restart;
            k_r       <= '0;
            found_r   <= 1'b0;
            best_r    <= '0;
            mask_r    <= '0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          rc_r[k_r]  <= count_down(rc_new);
          dc_r[k_r]  <= count_down(dc_new);
          bud_r[k_r] <= bud_new;
          mask_r     <= mask_nxt;
          if (take) begin
            found_r    <= 1'b1;
            best_r     <= dc_new;
            best_idx_r <= k_r;
          end
          if (last) begin
            // park the slot pointer on the winner for the budget charge
            k_r     <= take ? k_r : best_idx_r;
            state_r <= S_FIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (found_r) begin
              bud_r[k_r] <= bud_r[k_r] - 1'b1;
            end
            out_run_r   <= found_r ? edf_pkg::RUN_W'(k_r) : '0;
            out_idle_r  <= !found_r;
            out_mask_r  <= mask_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_run_task      = out_run_r;
  assign out_idle          = out_idle_r;
  assign out_released_mask = out_mask_r;

  // an idle tick never names a task
  a_idle_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> out_run_task == '0)
    else $error("idle result carries a task index");

  // the charged task still has budget
  a_charge_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && found_r |-> bud_r[k_r] != '0)
    else $error("winner has no budget to charge");

  // an accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while scanning");

  // reset leaves no pending result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

// File: tb/tb_top.sv
module tb_top;

  localparam int NT = edf_pkg::MAX_TASKS_DEF;
  localparam int TB = edf_pkg::TIME_BITS_DEF;

  // one scheduler decision as it leaves the block
  typedef struct packed {
    logic [edf_pkg::RUN_W-1:0]  run_task;
    logic                       idle;
    logic [edf_pkg::MASK_W-1:0] released;
  } grant_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_restart = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [edf_pkg::RUN_W-1:0]     out_run_task;
  logic                          out_idle;
  logic [edf_pkg::MASK_W-1:0]    out_released_mask;
  logic                          cfg_we = 1'b0;
  logic [edf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [edf_pkg::CFG_W-1:0]     cfg_data = '0;

  edf_tick_scheduler i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_run_task      (out_run_task),
    .out_idle          (out_idle),
    .out_released_mask (out_released_mask),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Shadow copy of the scheduler: registers plus the three per-slot counters.
  logic [edf_pkg::ACT_W-1:0] sched_active = edf_pkg::ACTIVE_RST;
  logic [edf_pkg::CFG_W-1:0] sched_setup [NT];
  logic [TB-1:0]             release_cnt [NT];
  logic [TB-1:0]             budget      [NT];
  logic [TB-1:0]             deadline_cnt[NT];

  logic   pending_ticks[$];    // restart flag of each request not yet offered
  grant_t expected_grants[$];  // decisions still owed by the block

  int  mismatches = 0;
  bit  fast_mode  = 0;         // no gaps on either side while set
  int  hold_req   = 0;         // bumped by the stimulus to ask for a long receiver stall
  int  hold_seen  = 0;
  int  hold_left  = 0;
  int  send_gap   = 0;
  int  recv_stall = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < NT; k++) begin
      sched_setup[k]  = '0;
      release_cnt[k]  = '0;
      budget[k]       = '0;
      deadline_cnt[k] = '0;
    end
  end

  // One tick of EDF: releases first, then the earliest deadline among tasks
  // with budget (lowest slot wins a tie), then every countdown saturates at 0.
  function automatic grant_t edf_advance(input logic restart);
    grant_t        g;
    int            used;
    int            pick;
    logic [TB-1:0] best;
    g    = '0;
    pick = -1;
    best = '0;
    used = (sched_active > NT) ? NT : int'(sched_active);
    if (restart) begin
      for (int k = 0; k < NT; k++) begin
        release_cnt[k]  = '0;
        budget[k]       = '0;
        deadline_cnt[k] = '0;
      end
    end
    for (int k = 0; k < used; k++) begin
      // zero period: slot disabled
      if (sched_setup[k][edf_pkg::PER_LSB +: TB] == '0) continue;
      if (release_cnt[k] == '0) begin
        budget[k]       = sched_setup[k][edf_pkg::CMP_LSB +: TB];
        deadline_cnt[k] = sched_setup[k][edf_pkg::DL_LSB +: TB];
        release_cnt[k]  = sched_setup[k][edf_pkg::PER_LSB +: TB];
        g.released[k]   = 1'b1;
      end
    end
    // a missed deadline leaves the countdown at zero, so that task stays most urgent
    for (int k = 0; k < used; k++) begin
      if (sched_setup[k][edf_pkg::PER_LSB +: TB] == '0 || budget[k] == '0) continue;
      if (pick < 0 || deadline_cnt[k] < best) begin
        pick = k;
        best = deadline_cnt[k];
      end
    end
    if (pick >= 0) begin
      budget[pick] = budget[pick] - 1'b1;
      g.run_task   = edf_pkg::RUN_W'(pick);
    end else begin
      g.idle = 1'b1;
    end
    for (int k = 0; k < NT; k++) begin
      if (release_cnt[k] != '0) release_cnt[k] = release_cnt[k] - 1'b1;
      if (deadline_cnt[k] != '0) deadline_cnt[k] = deadline_cnt[k] - 1'b1;
    end
    return g;
  endfunction

  function automatic logic [edf_pkg::CFG_W-1:0] pack_setup(input int per, input int cmp,
                                                           input int dl);
    return {16'(per), 16'(cmp), 16'(dl)};
  endfunction

  function automatic logic [edf_pkg::CFG_IDX_W-1:0] task_reg(input int k);
    return edf_pkg::CFG_IDX_W'(int'(edf_pkg::REG_TASK0) + k);
  endfunction

  // Single register write; the shadow copy follows it, out-of-range indexes drop.
  task automatic write_reg(input logic [edf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [edf_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == edf_pkg::REG_ACTIVE) sched_active = val[edf_pkg::ACT_W-1:0];
    else if (idx - edf_pkg::REG_TASK0 < NT) sched_setup[idx - edf_pkg::REG_TASK0] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Block is idle once nothing is queued, offered or owed; wait for that, then let it settle.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_grants.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
    end
  endtask

  // Request driver: the prediction is made at the accepting edge, then a
  // fresh gap is drawn before the next request goes out.
  always @(posedge clk) begin : tick_driver
    logic taken;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_restart <= 1'b0;
      send_gap = 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        expected_grants.push_back(edf_advance(in_restart));
        send_gap = fast_mode ? 0 : $urandom_range(0, 5);
      end
      if (in_valid && !taken) begin
        // request still waiting: hold it as is
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_valid   <= 1'b1;
        in_restart <= pending_ticks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver-side stall.
  always @(posedge clk) begin : grant_monitor
    grant_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: run %0d idle %0d mask %b",
                     out_run_task, out_idle, out_released_mask);
        end else begin
          want = expected_grants.pop_front();
          check_field("run_task", 32'(want.run_task), 32'(out_run_task));
          check_field("idle", 32'(want.idle), 32'(out_idle));
          check_field("released_mask", 32'(want.released), 32'(out_released_mask));
        end
        recv_stall = fast_mode ? 0 : $urandom_range(0, 5);
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, its own counter; the block should back up into in_ready.
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 80;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin : stimulus
    int                        r;
    int                        per;
    int                        cmp;
    int                        dl;
    int                        act;
    logic [edf_pkg::CFG_W-1:0] word;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setups: every period is zero, so every tick is idle.
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    wait_quiet();

    // Mixed slots: short period, all-ones setup, zero deadline, zero budget.
    // Writes to unused indexes must be dropped.
    write_reg(edf_pkg::REG_ACTIVE, edf_pkg::CFG_W'(4));
    write_reg(task_reg(0), pack_setup(4, 2, 3));
    write_reg(task_reg(1), {edf_pkg::CFG_W{1'b1}});
    write_reg(task_reg(2), pack_setup(1, 1, 0));
    write_reg(task_reg(3), pack_setup(3, 0, 5));
    write_reg(task_reg(NT), {edf_pkg::CFG_W{1'b1}});
    write_reg({edf_pkg::CFG_IDX_W{1'b1}}, {edf_pkg::CFG_W{1'b1}});
    for (int i = 0; i < 8; i++) pending_ticks.push_back(i == 5);
    wait_quiet();

    // Active count of zero idles everything; above the slot count it saturates.
    write_reg(edf_pkg::REG_ACTIVE, edf_pkg::CFG_W'(0));
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b0);
    wait_quiet();
    write_reg(edf_pkg::REG_ACTIVE, edf_pkg::CFG_W'(7));
    pending_ticks.push_back(1'b0);
    pending_ticks.push_back(1'b1);
    wait_quiet();

    // Identical slots tie on deadline; slot 0 must win. New setups land at next release.
    write_reg(edf_pkg::REG_ACTIVE, edf_pkg::CFG_W'(2));
    write_reg(task_reg(0), pack_setup(5, 3, 4));
    write_reg(task_reg(1), pack_setup(5, 3, 4));
    for (int i = 0; i < 6; i++) pending_ticks.push_back(i == 3);
    wait_quiet();

    // Random phases: mostly short periods so releases and deadline races are frequent.
    for (int ph = 0; ph < 8; ph++) begin
      fast_mode = (ph == 2);
      r = $urandom_range(0, 9);
      if (r == 0) act = 0;
      else if (r == 1) act = $urandom_range(5, 7);
      else act = $urandom_range(1, 4);
      write_reg(edf_pkg::REG_ACTIVE, edf_pkg::CFG_W'(act));
      for (int k = 0; k < NT; k++) begin
        if ($urandom_range(0, 3) == 0) continue;   // keep the old setup running
        if ($urandom_range(0, 5) == 0) begin
          word = {16'($urandom), 32'($urandom)};
        end else begin
          per  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
          cmp  = $urandom_range(0, per + 2);
          dl   = $urandom_range(0, per + 3);
          word = pack_setup(per, cmp, dl);
        end
        write_reg(task_reg(k), word);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(edf_pkg::CFG_IDX_W'($urandom_range(NT + 1, 7)),
                  {16'($urandom), 32'($urandom)});
      for (int i = 0; i < 55; i++)
        pending_ticks.push_back((i == 0 && ph % 2 == 0) || $urandom_range(0, 15) == 0);
      if (ph == 4) begin
        repeat (20) @(negedge clk);
        hold_req++;
      end
      wait_quiet();
    end
    fast_mode = 0;

    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_grants.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #800000;
    $display("simulation failed");
    $finish;
  end

endmodule
